// ===== hw/rtl/gated_block_loudness_unit_macros.svh =====
// ----------------------------------------------------------------------------
// gated block loudness unit assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GATED_BLOCK_LOUDNESS_UNIT_MACROS_SVH
`define GATED_BLOCK_LOUDNESS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define GBL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gbl assertion failed");
`define GBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gbl assertion failed");
`else
`define GBL_ASSERT(lbl, clk, rstn, prop)
`define GBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/gbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_pkg
// shared widths, codes, command structs and helpers of the loudness unit
// ----------------------------------------------------------------------------
package gbl_pkg;

  localparam int MaxBlocks = 64;
  localparam int AddrW     = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);
  localparam int SampleW   = 16;
  localparam int EnergyW   = 51;
  localparam int BsW       = 20;
  localparam int RatioW    = 17;
  localparam int MeanW     = 31;
  localparam int SumW      = EnergyW + AddrW;
  localparam int DenW      = CntW + BsW;
  // gate level wraps at 64 bits
  localparam int ThrW      = 64;
  localparam int DivCntW   = $clog2(SumW);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE     = 3'd0,
    CFG_BLOCKS_IN_USE  = 3'd1,
    CFG_MIN_BLOCKS     = 3'd2,
    CFG_GATING_RATIO   = 3'd3,
    CFG_IGNORE_SILENCE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_THR_MUL, ST_THR_PP, ST_THR_SUM, ST_LOAD_I, ST_CAP_I,
    ST_SWEEP, ST_FLUSH, ST_DECIDE, ST_DIV_SET, ST_DIV, ST_OUT
  } state_e;

  typedef struct packed {
    logic [BsW-1:0]    bs;
    logic [CntW-1:0]   biu;
    logic [CntW-1:0]   minb;
    logic [RatioW-1:0] ratio;
    logic              ign;
  } cfg_t;

  typedef struct packed {
    logic             acc;
    logic             thr_mul;
    logic             thr_pp;
    logic             thr_sum;
    logic             cap_i;
    logic             rd_en;
    logic             cmp;
    logic [AddrW-1:0] rd_addr;
    logic             decide;
    logic             div_start;
    logic             div_step;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic blk_end;
    logic div_last;
    logic out_busy;
  } stat_t;

  function automatic logic [BsW-1:0] eff_bs(input logic [BsW-1:0] bs);
    return (bs == '0) ? BsW'(1) : bs;
  endfunction

  function automatic logic [CntW-1:0] eff_win(input logic [CntW-1:0] biu);
    logic [CntW-1:0] n;
    n = biu;
    if (n == '0) n = CntW'(1);
    if (n > CntW'(MaxBlocks)) n = CntW'(MaxBlocks);
    return n;
  endfunction

endpackage

// ===== hw/rtl/gbl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl channel interfaces
// sample input channel and result output channel, valid/ready
// ----------------------------------------------------------------------------
interface gbl_sample_if import gbl_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gbl_result_if import gbl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MeanW-1:0] mean_power;
  logic [CntW-1:0]  included_blocks;
  modport source (output valid, output mean_power, output included_blocks, input ready);
  modport sink   (input valid, input mean_power, input included_blocks, output ready);
endinterface

// ===== hw/rtl/gbl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module gbl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gbl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_datapath
// energy accumulation, block ring, rank counting, gate and mean divider
// ----------------------------------------------------------------------------
`include "gated_block_loudness_unit_macros.svh"

module gbl_datapath import gbl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  cmd_t                      cmd_i,
  input  logic signed [SampleW-1:0] sample_i,
  output stat_t                     stat_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [MeanW-1:0]          mean_o,
  output logic [CntW-1:0]           incl_o
);

  logic [EnergyW-1:0] acc_q, acc_d;
  logic [BsW-1:0]     smp_cnt_q, smp_cnt_d;
  logic [AddrW-1:0]   slot_q, slot_d;
  logic [MaxBlocks-1:0] valid_q;
  logic [EnergyW-1:0] prev_mean_q;
  logic               out_valid_q;
  logic [MeanW-1:0]   out_mean_q;
  logic [CntW-1:0]    out_incl_q;

  logic signed [2*SampleW-1:0] sq_s;
  logic [EnergyW-1:0] acc_sum;
  logic [BsW-1:0]     cnt_inc;
  logic [BsW-1:0]     bs_eff;
  logic [CntW-1:0]    win;
  logic [AddrW-1:0]   slot_w;
  logic [CntW-1:0]    slot_nx;
  logic               wr_en;

  logic [EnergyW-1:0] ram_q;
  logic               rd_vld_q;
  logic [AddrW-1:0]   rd_addr_q;
  logic [EnergyW-1:0] e_rd;
  logic               cmp_en_q;
  logic [AddrW-1:0]   cmp_idx_q;
  logic [EnergyW-1:0] ei_q;
  logic [AddrW-1:0]   ei_idx_q;
  logic [CntW-1:0]    rank_q;

  logic [ThrW-1:0]         amul_q;
  logic [RatioW+15:0]      plo_q;
  logic [ThrW-1:0]         phi_q;
  logic [ThrW-1:0]         thr_q;
  logic [SumW-1:0]         sum_q;
  logic [CntW-1:0]         ccount_q;
  logic                    incl;

  logic [DenW-1:0]    den_q;
  logic [DenW:0]      rem_q;
  logic [SumW-1:0]    num_q;
  logic [DivCntW-1:0] divcnt_q;
  logic [DenW:0]      rem_sh;
  logic               q_bit;
  logic [EnergyW-1:0] mean_full;
  logic [MeanW-1:0]   mean_val;

  assign bs_eff  = eff_bs(cfg_i.bs);
  assign win     = eff_win(cfg_i.biu);
  assign sq_s    = sample_i * sample_i;
  assign acc_sum = acc_q + EnergyW'(sq_s[2*SampleW-2:0]);
  assign cnt_inc = smp_cnt_q + BsW'(1);
  assign stat_o.blk_end = (cnt_inc >= bs_eff);
  assign wr_en   = cmd_i.acc && stat_o.blk_end;
  assign slot_w  = ({1'b0, slot_q} >= win) ? '0 : slot_q;
  assign slot_nx = {1'b0, slot_w} + CntW'(1);

  always_comb begin
    acc_d     = acc_q;
    smp_cnt_d = smp_cnt_q;
    slot_d    = slot_q;
    if (cmd_i.acc) begin
      if (stat_o.blk_end) begin
        acc_d     = '0;
        smp_cnt_d = '0;
        slot_d    = (slot_nx >= win) ? '0 : slot_nx[AddrW-1:0];
      end else begin
        acc_d     = acc_sum;
        smp_cnt_d = cnt_inc;
      end
    end
  end

  gbl_ram #(.Width(EnergyW), .Depth(MaxBlocks)) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_w),
    .wdata_i (acc_sum),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (ram_q)
  );

  // entries never written read as zero
  assign e_rd = rd_vld_q ? ram_q : '0;

  assign incl = (rank_q < cfg_i.minb) || (ThrW'(ei_q) >= thr_q) ||
                (cfg_i.ign && (ei_q == '0));

  assign rem_sh = {rem_q[DenW-1:0], num_q[SumW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_q});
  assign mean_full = (ccount_q == '0) ? '0 : num_q[EnergyW-1:0];
  assign mean_val  = mean_full[MeanW-1:0];

  assign stat_o.div_last = (divcnt_q == DivCntW'(SumW - 1));
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      smp_cnt_q   <= '0;
      slot_q      <= '0;
      valid_q     <= '0;
      prev_mean_q <= '0;
      out_valid_q <= 1'b0;
      cmp_en_q    <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      smp_cnt_q <= smp_cnt_d;
      slot_q    <= slot_d;
      cmp_en_q  <= cmd_i.rd_en && cmd_i.cmp;
      if (wr_en) begin
        valid_q[slot_w] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        prev_mean_q <= mean_full;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q  <= valid_q[cmd_i.rd_addr];
    rd_addr_q <= cmd_i.rd_addr;
    cmp_idx_q <= cmd_i.rd_addr;
    if (cmd_i.thr_mul) begin
      amul_q   <= ThrW'(prev_mean_q) * ThrW'(bs_eff);
      sum_q    <= '0;
      ccount_q <= '0;
    end
    if (cmd_i.thr_pp) begin
      plo_q <= amul_q[15:0] * cfg_i.ratio;
      phi_q <= amul_q[ThrW-1:16] * ThrW'(cfg_i.ratio);
    end
    if (cmd_i.thr_sum) begin
      thr_q <= phi_q + ThrW'(plo_q[RatioW+15:16]);
    end
    if (cmd_i.cap_i) begin
      ei_q     <= e_rd;
      ei_idx_q <= rd_addr_q;
      rank_q   <= '0;
    end else if (cmp_en_q) begin
      // ties rank by ring position, as a stable sort would
      if ((e_rd > ei_q) || ((e_rd == ei_q) && (cmp_idx_q < ei_idx_q))) begin
        rank_q <= rank_q + CntW'(1);
      end
    end
    if (cmd_i.decide && incl) begin
      sum_q    <= sum_q + SumW'(ei_q);
      ccount_q <= ccount_q + CntW'(1);
    end
    if (cmd_i.div_start) begin
      den_q    <= DenW'(ccount_q) * DenW'(bs_eff);
      rem_q    <= '0;
      num_q    <= sum_q;
      divcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q    <= q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_q    <= {num_q[SumW-2:0], q_bit};
      divcnt_q <= divcnt_q + DivCntW'(1);
    end
    if (cmd_i.out_load) begin
      out_mean_q <= mean_val;
      out_incl_q <= ccount_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = out_mean_q;
  assign incl_o      = out_incl_q;

  `GBL_ASSERT_NEXT(a_block_clears, clk_i, rst_ni, wr_en, (acc_q == '0) && (smp_cnt_q == '0))
  `GBL_ASSERT(a_count_bound, clk_i, rst_ni, !cmd_i.decide || (ccount_q < CntW'(MaxBlocks)))
  `GBL_ASSERT(a_no_overwrite, clk_i, rst_ni, !cmd_i.out_load || !out_valid_q || out_ready_i)

endmodule

// ===== hw/rtl/gbl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_ctrl
// sequencer for sample intake, ranking sweeps, division and result load
// ----------------------------------------------------------------------------
module gbl_ctrl import gbl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] biu_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  stat_t           stat_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [CntW-1:0] win;

  assign win = eff_win(biu_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (stat_i.blk_end) state_d = ST_THR_MUL;
        end
      end
      ST_THR_MUL: begin
        cmd_o.thr_mul = 1'b1;
        i_d     = '0;
        state_d = ST_THR_PP;
      end
      ST_THR_PP: begin
        cmd_o.thr_pp = 1'b1;
        state_d = ST_THR_SUM;
      end
      ST_THR_SUM: begin
        cmd_o.thr_sum = 1'b1;
        state_d = ST_LOAD_I;
      end
      ST_LOAD_I: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = i_q[AddrW-1:0];
        state_d = ST_CAP_I;
      end
      ST_CAP_I: begin
        cmd_o.cap_i = 1'b1;
        j_d     = '0;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cmp     = 1'b1;
        cmd_o.rd_addr = j_q[AddrW-1:0];
        j_d = j_q + CntW'(1);
        if (j_d >= win) state_d = ST_FLUSH;
      end
      // last compare lands here
      ST_FLUSH: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        i_d = i_q + CntW'(1);
        state_d = (i_d >= win) ? ST_DIV_SET : ST_LOAD_I;
      end
      ST_DIV_SET: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/gated_block_loudness_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated block loudness unit
// gated mean block energy over a ring of recent sample blocks
// ----------------------------------------------------------------------------
// in_s carries signed 16-bit samples; out_s carries one result per finished
// block: the gated mean power and the count of included blocks.
// a sample that does not end a block is taken and gives no result. the
// sample that ends a block starts ranking: each of the n window entries
// (n = blocks_in_use, 1..64) is read once and compared against all n
// entries through the single ring read port, then a bit-serial divider
// forms the mean. in_s is not ready during that time.
// the result sits in an output register, so samples keep flowing while it
// waits; if out_s stalls and another block ends, that block waits before
// loading its result.
// reset clears the accumulator, ring (through per-entry valid bits), write
// slot and previous mean, and loads the default registers. the cfg port
// writes one register per cycle when cfg_we_i is high; write only when idle.
// ----------------------------------------------------------------------------
module gated_block_loudness_unit import gbl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  gbl_sample_if.sink          in_s,
  gbl_result_if.source        out_s,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bs    <= BsW'(2400);
      cfg_q.biu   <= CntW'(20);
      cfg_q.minb  <= CntW'(10);
      cfg_q.ratio <= RatioW'(6554);
      cfg_q.ign   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BLOCK_SIZE:     cfg_q.bs    <= cfg_wdata_i[BsW-1:0];
        CFG_BLOCKS_IN_USE:  cfg_q.biu   <= cfg_wdata_i[CntW-1:0];
        CFG_MIN_BLOCKS:     cfg_q.minb  <= cfg_wdata_i[CntW-1:0];
        CFG_GATING_RATIO:   cfg_q.ratio <= cfg_wdata_i[RatioW-1:0];
        CFG_IGNORE_SILENCE: cfg_q.ign   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  gbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .biu_i      (cfg_q.biu),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gbl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sample_i    (in_s.sample),
    .stat_o      (stat),
    .out_ready_i (out_s.ready),
    .out_valid_o (out_s.valid),
    .mean_o      (out_s.mean_power),
    .incl_o      (out_s.included_blocks)
  );

endmodule
